### rtl/core/bsc_pkg.sv
// Package for the barometric sensor compensation block.
// Holds shared constants, the coefficient register indices and the shift and sign-extension helpers.
`timescale 1ns / 1ps
package bsc_pkg;
    localparam int OVERSAMPLING_DEFAULT = 3;
    localparam int CFG_IDX_W = 3;
    localparam logic [31:0] C_4000 = 32'd4000;
    localparam logic [31:0] C_32768 = 32'd32768;
    localparam logic [31:0] C_50000 = 32'd50000;
    localparam logic [31:0] C_SIGN = 32'h8000_0000;
    localparam logic [31:0] C_3038 = 32'd3038;
    localparam logic [31:0] C_M7357 = 32'hFFFF_E343;
    localparam logic [31:0] C_3791 = 32'd3791;

    localparam logic [CFG_IDX_W-1:0] REG_AC1 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_AC2 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_AC3 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_AC4 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_B1 = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_B2 = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_AC56 = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_MCMD = 3'd7;

    function automatic logic [31:0] asr(input logic [31:0] v, input logic [4:0] n);
        asr = 32'($signed(v) >>> n);
    endfunction

    function automatic logic [31:0] sx16(input logic [15:0] v);
        sx16 = {{16{v[15]}}, v};
    endfunction
endpackage

### rtl/core/barometric_sensor_compensation.sv
// Top level of the barometric sensor compensation block.
// Depends on bsc_pkg, bsc_mul and bsc_div.
// Converts raw temperature and pressure beats into calibrated values with the stored
// coefficients. A sequencer runs every product through one shared multiplier and each
// division through a bit-serial divider. When the divisor is zero the division is skipped
// and a zero value is presented with divide_error set. in_stall stays high from acceptance
// until the result beat is taken, so the block takes a new beat only after the last result
// beat is taken. The user must write coefficients only while no beat is in flight; the
// block itself does not enforce this.
`timescale 1ns / 1ps
module barometric_sensor_compensation
#(
    parameter int OVERSAMPLING = bsc_pkg::OVERSAMPLING_DEFAULT
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [bsc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [31:0]                    cfg_data,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic                           mode,
    input  logic [23:0]                    raw_reading,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic                           result_kind,
    output logic signed [31:0]             measured_value,
    output logic                           divide_error
);
    import bsc_pkg::*;

    localparam logic MODE_PRES = 1'b1;

    typedef enum logic [5:0]
    {
        S_IDLE = 6'b000001,
        S_MUL  = 6'b000010,
        S_CALC = 6'b000100,
        S_DIV  = 6'b001000,
        S_DWT  = 6'b010000,
        S_OUT  = 6'b100000
    } state_t;

    typedef enum logic [12:0]
    {
        ST_T_X1  = 13'b0000000000001,
        ST_T_B5  = 13'b0000000000010,
        ST_P_SQ  = 13'b0000000000100,
        ST_P_B2  = 13'b0000000001000,
        ST_P_AC2 = 13'b0000000010000,
        ST_P_AC3 = 13'b0000000100000,
        ST_P_B1  = 13'b0000001000000,
        ST_P_B4  = 13'b0000010000000,
        ST_P_B7  = 13'b0000100000000,
        ST_P_DIV = 13'b0001000000000,
        ST_P_PSQ = 13'b0010000000000,
        ST_P_C1  = 13'b0100000000000,
        ST_P_C2  = 13'b1000000000000
    } step_t;

    state_t state_reg, state_next;
    step_t step_reg, step_next;
    logic [15:0] ac1_reg, ac2_reg, ac3_reg, ac4_reg, b1_reg, b2_reg;
    logic [31:0] ac56_reg, mcmd_reg;
    logic [15:0] b5_reg, b5_next;
    logic mode_reg, mode_next;
    logic [23:0] raw_reg, raw_next;
    logic [31:0] t0_reg, t0_next, t1_reg, t1_next, t2_reg, t2_next;
    logic [31:0] t3_reg, t3_next, acc_reg, acc_next;
    logic [31:0] val_reg, val_next;
    logic err_reg, err_next;
    logic [31:0] ma, mb, mp;
    logic div_start, div_done;
    logic [31:0] dvd, dvs, quo;
    logic [31:0] x1_w, den_w, x2_t, q_t, b5_sum, up_w, b3_w, p_w;

    bsc_mul u_mul (.clk(clk), .a(ma), .b(mb), .p(mp));
    bsc_div u_div (.clk(clk), .rst_n(rst_n), .start(div_start), .dividend(dvd),
        .divisor(dvs), .done(div_done), .quotient(quo));

    always_comb
    begin
        ma = '0;
        mb = '0;
        unique case (step_reg)
            ST_T_X1:
            begin
                ma = {16'd0, raw_reg[15:0]} - {16'd0, ac56_reg[15:0]};
                mb = {16'd0, ac56_reg[31:16]};
            end
            ST_P_SQ:
            begin
                ma = t0_reg;
                mb = t0_reg;
            end
            ST_P_B2:
            begin
                ma = sx16(b2_reg);
                mb = t1_reg;
            end
            ST_P_AC2:
            begin
                ma = sx16(ac2_reg);
                mb = t0_reg;
            end
            ST_P_AC3:
            begin
                ma = sx16(ac3_reg);
                mb = t0_reg;
            end
            ST_P_B1:
            begin
                ma = sx16(b1_reg);
                mb = t1_reg;
            end
            ST_P_B4:
            begin
                ma = {16'd0, ac4_reg};
                mb = t1_reg;
            end
            ST_P_B7:
            begin
                ma = t2_reg;
                mb = 32'(C_50000 >> OVERSAMPLING);
            end
            ST_P_PSQ:
            begin
                ma = t1_reg;
                mb = t1_reg;
            end
            ST_P_C1:
            begin
                ma = t1_reg;
                mb = C_3038;
            end
            ST_P_C2:
            begin
                ma = C_M7357;
                mb = acc_reg;
            end
            default: ;
        endcase
    end

    // The temperature division runs on magnitudes; the sign is put back afterwards.
    assign x2_t = sx16(mcmd_reg[31:16]) << 11;
    assign x1_w = asr(mp, 5'd15);
    assign den_w = x1_w + sx16(mcmd_reg[15:0]);
    assign q_t = (x2_t[31] ^ t0_reg[31]) ? (32'd0 - quo) : quo;
    assign b5_sum = t1_reg + q_t;
    assign up_w = 32'({8'd0, raw_reg} >> (8 - OVERSAMPLING));
    assign b3_w = asr((((sx16(ac1_reg) << 2) + acc_reg + asr(mp, 5'd11)) << OVERSAMPLING)
                      + 32'd2, 5'd2);
    assign p_w = t2_reg[31] ? {quo[30:0], 1'b0} : quo;

    assign dvd = (step_reg == ST_T_B5) ? (x2_t[31] ? (32'd0 - x2_t) : x2_t)
               : (t2_reg[31] ? t2_reg : {t2_reg[30:0], 1'b0});
    assign dvs = (step_reg == ST_T_B5) ? (t0_reg[31] ? (32'd0 - t0_reg) : t0_reg)
               : t3_reg;
    assign div_start = (state_reg == S_DIV);

    always_comb
    begin
        state_next = state_reg;
        step_next = step_reg;
        b5_next = b5_reg;
        mode_next = mode_reg;
        raw_next = raw_reg;
        t0_next = t0_reg;
        t1_next = t1_reg;
        t2_next = t2_reg;
        t3_next = t3_reg;
        acc_next = acc_reg;
        val_next = val_reg;
        err_next = err_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    mode_next = mode;
                    raw_next = raw_reading;
                    t0_next = sx16(b5_reg) - C_4000;
                    step_next = (mode == MODE_PRES) ? ST_P_SQ : ST_T_X1;
                    state_next = S_MUL;
                end
            end
            S_MUL: state_next = S_CALC;
            S_DIV: state_next = S_DWT;
            S_DWT:
            begin
                if (div_done)
                begin
                    state_next = S_CALC;
                end
            end
            S_OUT:
            begin
                if (!out_stall)
                begin
                    state_next = S_IDLE;
                end
            end
            S_CALC:
            begin
                state_next = S_MUL;
                unique case (step_reg)
                    ST_T_X1:
                    begin
                        t1_next = x1_w;
                        t0_next = den_w;
                        if (den_w == 32'd0)
                        begin
                            val_next = '0;
                            err_next = 1'b1;
                            state_next = S_OUT;
                        end
                        else
                        begin
                            step_next = ST_T_B5;
                            state_next = S_DIV;
                        end
                    end
                    ST_T_B5:
                    begin
                        b5_next = b5_sum[15:0];
                        val_next = asr(sx16(b5_sum[15:0]) + 32'd8, 5'd4);
                        err_next = 1'b0;
                        state_next = S_OUT;
                    end
                    ST_P_SQ:
                    begin
                        t1_next = asr(mp, 5'd12);
                        step_next = ST_P_B2;
                    end
                    ST_P_B2:
                    begin
                        acc_next = asr(mp, 5'd11);
                        step_next = ST_P_AC2;
                    end
                    ST_P_AC2:
                    begin
                        t2_next = up_w - b3_w;
                        step_next = ST_P_AC3;
                    end
                    ST_P_AC3:
                    begin
                        acc_next = asr(mp, 5'd13);
                        step_next = ST_P_B1;
                    end
                    ST_P_B1:
                    begin
                        t1_next = asr(acc_reg + asr(mp, 5'd16) + 32'd2, 5'd2) + C_32768;
                        step_next = ST_P_B4;
                    end
                    ST_P_B4:
                    begin
                        t3_next = mp >> 15;
                        step_next = ST_P_B7;
                    end
                    ST_P_B7:
                    begin
                        t2_next = mp;
                        if (t3_reg == 32'd0)
                        begin
                            val_next = '0;
                            err_next = 1'b1;
                            state_next = S_OUT;
                        end
                        else
                        begin
                            step_next = ST_P_DIV;
                            state_next = S_DIV;
                        end
                    end
                    ST_P_DIV:
                    begin
                        acc_next = p_w;
                        t1_next = asr(p_w, 5'd8);
                        step_next = ST_P_PSQ;
                    end
                    ST_P_PSQ:
                    begin
                        t1_next = mp;
                        step_next = ST_P_C1;
                    end
                    ST_P_C1:
                    begin
                        t1_next = asr(mp, 5'd16);
                        step_next = ST_P_C2;
                    end
                    ST_P_C2:
                    begin
                        val_next = acc_reg + asr(t1_reg + asr(mp, 5'd16) + C_3791, 5'd4);
                        err_next = 1'b0;
                        state_next = S_OUT;
                    end
                    default: state_next = S_IDLE;
                endcase
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            step_reg <= ST_T_X1;
            ac1_reg <= '0;
            ac2_reg <= '0;
            ac3_reg <= '0;
            ac4_reg <= '0;
            b1_reg <= '0;
            b2_reg <= '0;
            ac56_reg <= '0;
            mcmd_reg <= '0;
            b5_reg <= '0;
            mode_reg <= 1'b0;
            raw_reg <= '0;
            t0_reg <= '0;
            t1_reg <= '0;
            t2_reg <= '0;
            t3_reg <= '0;
            acc_reg <= '0;
            val_reg <= '0;
            err_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg <= step_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_AC1: ac1_reg <= cfg_data[15:0];
                    REG_AC2: ac2_reg <= cfg_data[15:0];
                    REG_AC3: ac3_reg <= cfg_data[15:0];
                    REG_AC4: ac4_reg <= cfg_data[15:0];
                    REG_B1: b1_reg <= cfg_data[15:0];
                    REG_B2: b2_reg <= cfg_data[15:0];
                    REG_AC56: ac56_reg <= cfg_data;
                    REG_MCMD: mcmd_reg <= cfg_data;
                    default: ;
                endcase
            end
            b5_reg <= b5_next;
            mode_reg <= mode_next;
            raw_reg <= raw_next;
            t0_reg <= t0_next;
            t1_reg <= t1_next;
            t2_reg <= t2_next;
            t3_reg <= t3_next;
            acc_reg <= acc_next;
            val_reg <= val_next;
            err_reg <= err_next;
        end
    end

    assign in_stall = (state_reg != S_IDLE);
    assign out_valid = (state_reg == S_OUT);
    assign result_kind = mode_reg;
    assign measured_value = val_reg;
    assign divide_error = err_reg;
endmodule

### rtl/core/bsc_mul.sv
// Shared 32x32 multiplier returning the low 32 bits, registered.
// Depends on nothing beyond the clock.
`timescale 1ns / 1ps
module bsc_mul
(
    input  logic        clk,
    input  logic [31:0] a,
    input  logic [31:0] b,
    output logic [31:0] p
);
    logic [31:0] p_reg;
    always_ff @(posedge clk)
    begin
        p_reg <= a * b;
    end
    assign p = p_reg;
endmodule

### rtl/core/bsc_div.sv
// Radix-2 restoring unsigned divider, one quotient bit per cycle.
// Depends on nothing beyond the clock and reset.
`timescale 1ns / 1ps
module bsc_div
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] dividend,
    input  logic [31:0] divisor,
    output logic        done,
    output logic [31:0] quotient
);
    logic [31:0] q_reg, q_next;
    logic [31:0] r_reg, r_next;
    logic [31:0] d_reg;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic [32:0] trial;

    always_comb
    begin
        q_next = q_reg;
        r_next = r_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        trial = {r_reg, q_reg[31]} - {1'b0, d_reg};
        if (start)
        begin
            q_next = dividend;
            r_next = '0;
            cnt_next = 6'd32;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!trial[32])
            begin
                r_next = trial[31:0];
                q_next = {q_reg[30:0], 1'b1};
            end
            else
            begin
                r_next = {r_reg[30:0], q_reg[31]};
                q_next = {q_reg[30:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        if (start)
        begin
            d_reg <= divisor;
        end
    end

    assign done = busy_reg && (cnt_reg == 6'd1);
    assign quotient = q_next;
endmodule

### dv/tb_barometric_sensor_compensation.sv
// Self-checking testbench for the barometric sensor compensation block.
// Depends on bsc_pkg and the barometric_sensor_compensation RTL; reads no files.
`timescale 1ns / 1ps
module tb_barometric_sensor_compensation;
    import bsc_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam logic MODE_TEMP = 1'b0;
    localparam logic MODE_PRES = 1'b1;

    typedef struct packed {
        logic        kind;
        logic [31:0] value;
        logic        err;
    } reading_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [31:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic mode = 1'b0;
    logic [23:0] raw_reading = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic result_kind;
    logic signed [31:0] measured_value;
    logic divide_error;

    logic [31:0] cal_ac1, cal_ac2, cal_ac3, cal_ac4, cal_b1, cal_b2, cal_ac56, cal_mcmd;
    logic [31:0] model_b5;
    reading_t expected_readings[$];
    int errors = 0;
    int idle_cycles = 0;
    bit stall_on = 1'b0;

    barometric_sensor_compensation dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .in_valid(in_valid), .in_stall(in_stall), .mode(mode),
        .raw_reading(raw_reading), .out_valid(out_valid), .out_stall(out_stall),
        .result_kind(result_kind), .measured_value(measured_value),
        .divide_error(divide_error)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic logic [31:0] sext16(input logic [31:0] v);
        return {{16{v[15]}}, v[15:0]};
    endfunction

    function automatic logic [31:0] shr_s(input logic [31:0] v, input int n);
        return $signed(v) >>> n;
    endfunction

    function automatic logic [31:0] quot_s(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] ma, mb, q;
        ma = a[31] ? -a : a;
        mb = b[31] ? -b : b;
        q = ma / mb;
        return (a[31] != b[31]) ? -q : q;
    endfunction

    function automatic reading_t compensate(input logic md_sel, input logic [23:0] raw);
        reading_t r;
        logic [31:0] ut, x1, x2, x3, den, b5, up, b6, sq, b3, b4, b7, p;
        r.kind = md_sel;
        r.value = '0;
        r.err = 1'b0;
        if (md_sel == MODE_TEMP)
        begin
            ut = {16'd0, raw[15:0]};
            x1 = shr_s((ut - {16'd0, cal_ac56[15:0]}) * {16'd0, cal_ac56[31:16]}, 15);
            x2 = sext16({16'd0, cal_mcmd[31:16]}) << 11;
            den = x1 + sext16(cal_mcmd);
            if (den == 0)
            begin
                r.err = 1'b1;
            end
            else
            begin
                b5 = sext16(x1 + quot_s(x2, den));
                model_b5 = b5;
                r.value = shr_s(b5 + 8, 4);
            end
        end
        else
        begin
            up = {8'd0, raw} >> (8 - OVERSAMPLING_DEFAULT);
            b6 = sext16(model_b5) - 32'd4000;
            sq = shr_s(b6 * b6, 12);
            x1 = shr_s(sext16(cal_b2) * sq, 11);
            x2 = shr_s(sext16(cal_ac2) * b6, 11);
            x3 = x1 + x2;
            b3 = shr_s(((sext16(cal_ac1) * 4 + x3) << OVERSAMPLING_DEFAULT) + 2, 2);
            x1 = shr_s(sext16(cal_ac3) * b6, 13);
            x2 = shr_s(sext16(cal_b1) * sq, 16);
            x3 = shr_s(x1 + x2 + 2, 2);
            b4 = ({16'd0, cal_ac4[15:0]} * (x3 + 32'd32768)) >> 15;
            b7 = (up - b3) * (32'd50000 >> OVERSAMPLING_DEFAULT);
            if (b4 == 0)
            begin
                r.err = 1'b1;
            end
            else
            begin
                if (!b7[31])
                    p = (b7 << 1) / b4;
                else
                    p = (b7 / b4) << 1;
                x1 = shr_s(p, 8);
                x1 = x1 * x1;
                x1 = shr_s(x1 * 32'd3038, 16);
                x2 = shr_s(32'hFFFF_E343 * p, 16);
                r.value = p + shr_s(x1 + x2 + 32'd3791, 4);
            end
        end
        return r;
    endfunction

    always @(posedge clk)
    begin
        reading_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_readings.size() == 0)
            begin
                $error("result beat with nothing expected: value %0d", measured_value);
                errors++;
            end
            else
            begin
                e = expected_readings.pop_front();
                if (result_kind !== e.kind)
                begin
                    $error("result_kind expected %0d actual %0d", e.kind, result_kind);
                    errors++;
                end
                if (measured_value !== e.value)
                begin
                    $error("measured_value expected %0d actual %0d",
                           $signed(e.value), measured_value);
                    errors++;
                end
                if (divide_error !== e.err)
                begin
                    $error("divide_error expected %0d actual %0d", e.err, divide_error);
                    errors++;
                end
            end
        end
    end

    // Receiver stall pattern: alternating runs, sometimes long stretches of no stall.
    always @(negedge clk)
    begin
        if ($urandom_range(0, 15) == 0)
            stall_on = ($urandom_range(0, 2) == 0);
        out_stall <= stall_on ? ($urandom_range(0, 1) == 1) : 1'b0;
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("barometric_sensor_compensation regression: fail");
            $finish;
        end
    end

    task automatic write_coef(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_AC1: cal_ac1 = {16'd0, val[15:0]};
            REG_AC2: cal_ac2 = {16'd0, val[15:0]};
            REG_AC3: cal_ac3 = {16'd0, val[15:0]};
            REG_AC4: cal_ac4 = {16'd0, val[15:0]};
            REG_B1: cal_b1 = {16'd0, val[15:0]};
            REG_B2: cal_b2 = {16'd0, val[15:0]};
            REG_AC56: cal_ac56 = val;
            default: cal_mcmd = val;
        endcase
    endtask

    task automatic write_cal_set(input logic [31:0] a1, a2, a3, a4, b1, b2, a56, mcmd);
        write_coef(REG_AC1, a1);
        write_coef(REG_AC2, a2);
        write_coef(REG_AC3, a3);
        write_coef(REG_AC4, a4);
        write_coef(REG_B1, b1);
        write_coef(REG_B2, b2);
        write_coef(REG_AC56, a56);
        write_coef(REG_MCMD, mcmd);
    endtask

    // Sends one beat; keeps valid high when another beat follows directly.
    task automatic send_reading(input logic md_sel, input logic [23:0] raw,
                                input bit keep);
        @(negedge clk);
        in_valid <= 1'b1;
        mode <= md_sel;
        raw_reading <= raw;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        expected_readings.push_back(compensate(md_sel, raw));
        if (!keep)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
    endtask

    task automatic drain_results();
        while (expected_readings.size() != 0)
            @(posedge clk);
        repeat (80) @(posedge clk);
    endtask

    task automatic send_burst_traffic(input int count);
        int left, burst;
        left = count;
        while (left > 0)
        begin
            burst = $urandom_range(1, 12);
            if (burst > left)
                burst = left;
            for (int i = 0; i < burst; i++)
            begin
                if ($urandom_range(0, 2) == 0)
                    send_reading(MODE_TEMP, 24'($urandom), i != burst - 1);
                else
                    send_reading(MODE_PRES, 24'($urandom), i != burst - 1);
            end
            left -= burst;
            if ($urandom_range(0, 3) != 0)
                repeat ($urandom_range(1, 60)) @(negedge clk);
        end
    endtask

    task automatic test_reset_defaults();
        // All coefficients zero: both divisors vanish.
        send_reading(MODE_PRES, 24'h123456, 1'b0);
        send_reading(MODE_TEMP, 24'hFFFFFF, 1'b0);
        drain_results();
    endtask

    task automatic test_typical_calibration();
        write_cal_set(32'd408, -32'd72, -32'd14383, 32'd32741, 32'd6190, 32'd4,
                      {16'd32757, 16'd23153}, {-16'sd8711, 16'd2868});
        send_reading(MODE_TEMP, 24'h006C50, 1'b0);
        send_reading(MODE_PRES, 24'h5D23C0, 1'b1);
        send_reading(MODE_PRES, 24'h000000, 1'b1);
        send_reading(MODE_PRES, 24'hFFFFFF, 1'b0);
        send_reading(MODE_TEMP, 24'hFF0000, 1'b0);
        send_reading(MODE_TEMP, 24'h00FFFF, 1'b0);
        send_reading(MODE_PRES, 24'hAAAAAA, 1'b0);
        send_reading(MODE_PRES, 24'h555555, 1'b0);
        drain_results();
    endtask

    task automatic test_zero_temp_divisor();
        // UT equals AC6, so X1 is zero, and MD is zero: the denominator is zero.
        write_cal_set(32'd408, -32'd72, -32'd14383, 32'd32741, 32'd6190, 32'd4,
                      {16'd32757, 16'd23153}, {-16'sd8711, 16'd0});
        send_reading(MODE_TEMP, 24'd23153, 1'b0);
        send_reading(MODE_PRES, 24'h5D23C0, 1'b0);
        drain_results();
    endtask

    task automatic test_extreme_coefficients();
        write_cal_set(32'h8000, 32'h7FFF, 32'h8000, 32'hFFFF, 32'h7FFF, 32'h8000,
                      32'hFFFF_FFFF, 32'h8000_7FFF);
        send_reading(MODE_TEMP, 24'h000000, 1'b0);
        send_reading(MODE_PRES, 24'hFFFFFF, 1'b0);
        send_reading(MODE_TEMP, 24'h00FFFF, 1'b0);
        send_reading(MODE_PRES, 24'h000001, 1'b0);
        drain_results();
        write_cal_set(32'h7FFF, 32'h8000, 32'h7FFF, 32'h0001, 32'h8000, 32'h7FFF,
                      32'h0000_0000, 32'h7FFF_8000);
        send_reading(MODE_TEMP, 24'h123456, 1'b0);
        send_reading(MODE_PRES, 24'h800000, 1'b0);
        write_cal_pause();
    endtask

    task automatic write_cal_pause();
        drain_results();
    endtask

    task automatic test_random_traffic();
        for (int phase = 0; phase < 4; phase++)
        begin
            if (phase == 0)
                write_cal_set(32'd408, -32'd72, -32'd14383, 32'd32741, 32'd6190, 32'd4,
                              {16'd32757, 16'd23153}, {-16'sd8711, 16'd2868});
            else
                write_cal_set($urandom, $urandom, $urandom, $urandom, $urandom,
                              $urandom, $urandom, $urandom);
            send_burst_traffic(220);
            drain_results();
        end
    endtask

    initial
    begin
        cal_ac1 = '0; cal_ac2 = '0; cal_ac3 = '0; cal_ac4 = '0;
        cal_b1 = '0; cal_b2 = '0; cal_ac56 = '0; cal_mcmd = '0;
        model_b5 = '0;
        repeat (7) @(negedge clk);
        rst_n = 1'b1;
        test_reset_defaults();
        test_typical_calibration();
        test_zero_temp_divisor();
        test_extreme_coefficients();
        test_random_traffic();
        if (errors == 0 && expected_readings.size() == 0)
            $display("barometric_sensor_compensation regression: pass");
        else
            $display("barometric_sensor_compensation regression: fail");
        $finish;
    end
endmodule

### barometric_sensor_compensation.f
rtl/core/bsc_pkg.sv
rtl/core/bsc_mul.sv
rtl/core/bsc_div.sv
rtl/core/barometric_sensor_compensation.sv
dv/tb_barometric_sensor_compensation.sv
